// ===== rtl/ldwf_pkg.sv =====
// ----------------------------------------------------------------------------
// ldwf_pkg
// shared constants, types and the reciprocal table of the line filter
// ----------------------------------------------------------------------------
package ldwf_pkg;

   localparam int MaxKernel = 7;
   localparam int MaxWidth  = 1024;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int WinW      = $clog2(MaxKernel);
   localparam int RecipW    = 19;
   localparam int RecipSh   = 20;
   localparam int SumW      = 16;
   localparam int ProdW     = 34;

   localparam logic [1:0] CsrOrientation = 2'd0;
   localparam logic [1:0] CsrKernelSize  = 2'd1;
   localparam logic [1:0] CsrLineWidth   = 2'd2;

   typedef struct packed {
      logic load;
      logic update;
      logic acc_step;
      logic mul;
      logic out_load;
   } ldwf_cmd_type;

   typedef struct packed {
      logic col_last;
      logic rsp_free;
   } ldwf_sts_type;

   // ceil(2^20 / (k*k))
   function automatic logic [RecipW-1:0] recip(input logic [2:0] k);
      logic [RecipW-1:0] r;
      begin
         case (k)
            3'd2: r = 19'd262144;
            3'd3: r = 19'd116509;
            3'd4: r = 19'd65536;
            3'd5: r = 19'd41944;
            3'd6: r = 19'd29128;
            3'd7: r = 19'd21400;
            default: r = 19'd262144;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== rtl/line_detect_window_filter.sv =====
// each pixel is taken in idle and passes line store read, window update, the
// seven-step column accumulation, scaling multiply and output load, which waits
// while the result side is busy, before the next pixel is accepted
// reset: synchronous active high; CSRs to defaults, window cleared, line store not cleared
// ----------------------------------------------------------------------------
// line_detect_window_filter
// streaming k-by-k line detection filter over raster grey pixels
// ----------------------------------------------------------------------------
module line_detect_window_filter import ldwf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // pixel
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // response
   output logic        rsp_tuser,   // window_valid
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   ldwf_cmd_type cmd;
   ldwf_sts_type sts;

   ldwf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ldwf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== rtl/ldwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldwf_ctrl
// sequencer: read, window update, column accumulation, scaling, output
// ----------------------------------------------------------------------------
module ldwf_ctrl import ldwf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ldwf_sts_type sts,
   output ldwf_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_ACC  = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.update = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_step = 1'b1;
            if (sts.col_last) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef ASSERT_OFF
   a_load_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_READ) else $error("load not followed by read");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.rsp_free) else $error("result overwritten");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.update && !cmd.acc_step) else $error("ready while busy");
`endif

endmodule

// ===== rtl/ldwf_datapath.sv =====
// ----------------------------------------------------------------------------
// ldwf_datapath
// line store, window registers, accumulator, reciprocal scaling, output beat
// ----------------------------------------------------------------------------
module ldwf_datapath import ldwf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_wdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic         rsp_tuser,
   input  ldwf_cmd_type cmd,
   output ldwf_sts_type sts
);

   localparam int RowW = 8 * (MaxKernel - 1);

   logic [RowW-1:0] mem [MaxWidth];
   logic [RowW-1:0] rd_ff;

   logic            orient_ff;
   logic [2:0]      ksize_ff;
   logic [10:0]     lwidth_ff;
   logic [ColW-1:0] cnt_ff, cnt_in;
   logic [2:0]      rows_ff;
   logic [ColW-1:0] c_ff;
   logic [7:0]      pix_ff;
   logic [7:0]      win_ff [MaxKernel][MaxKernel];
   logic [WinW-1:0] q_ff;
   logic signed [SumW-1:0] acc_ff;
   logic [ProdW-1:0]       prod_ff;
   logic            valid_ff;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_data_ff;
   logic            rsp_user_ff;

   logic [2:0]      k_eff;
   logic [10:0]     w_eff;
   logic [ColW-1:0] c_new;
   logic [2:0]      base, cm;
   logic signed [SumW-1:0] col_sum;
   logic [ProdW-ColW-RecipSh+9:0] quo;

   always_comb begin
      k_eff = (ksize_ff < 3'd2) ? 3'd2 : ksize_ff;
      if (lwidth_ff < 11'd8) w_eff = 11'd8;
      else if (lwidth_ff > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
      else w_eff = lwidth_ff;
      if (req_tuser) c_new = '0;
      else if ({1'b0, cnt_ff} >= w_eff) c_new = ColW'(w_eff - 11'd1);
      else c_new = cnt_ff;
      base = 3'(MaxKernel) - k_eff;
      cm   = base + ((k_eff - 3'd1) >> 1);
   end

   always_comb begin
      col_sum = '0;
      for (int p = 0; p < MaxKernel; p++) begin
         if (3'(p) >= base && 3'(q_ff) >= base) begin
            if ((orient_ff ? 3'(q_ff) : 3'(p)) == cm)
               col_sum = col_sum + SumW'(k_eff - 3'd1) * $signed({8'd0, win_ff[p][q_ff]});
            else
               col_sum = col_sum - $signed({8'd0, win_ff[p][q_ff]});
         end
      end
      quo = prod_ff[ProdW-1:RecipSh];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rd_ff <= mem[c_new];
      if (cmd.update) mem[c_ff] <= {rd_ff[RowW-9:0], pix_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff <= 1'b0;
         ksize_ff  <= 3'd3;
         lwidth_ff <= 11'd640;
      end else if (csr_we) begin
         case (csr_index)
            CsrOrientation: orient_ff <= csr_wdata[0];
            CsrKernelSize:  ksize_ff  <= csr_wdata[2:0];
            CsrLineWidth:   lwidth_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cnt_in = c_ff + ColW'(1);
      if ({1'b0, c_ff} + 11'd1 >= w_eff) cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rows_ff <= '0;
         for (int r = 0; r < MaxKernel; r++)
            for (int l = 0; l < MaxKernel; l++) win_ff[r][l] <= '0;
      end else begin
         if (cmd.load && req_tuser) rows_ff <= '0;
         if (cmd.update) begin
            cnt_ff <= cnt_in;
            if (cnt_in == '0 && rows_ff < 3'(MaxKernel - 1)) rows_ff <= rows_ff + 3'd1;
            for (int r = 0; r < MaxKernel; r++) begin
               for (int l = 0; l < MaxKernel - 1; l++) win_ff[r][l] <= win_ff[r][l+1];
               if (r == MaxKernel - 1) win_ff[r][MaxKernel-1] <= pix_ff;
               else win_ff[r][MaxKernel-1] <= rd_ff[8*(MaxKernel-2-r) +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_ff   <= c_new;
         pix_ff <= req_tdata;
      end
      if (cmd.update) begin
         valid_ff <= (rows_ff >= k_eff - 3'd1) && (c_ff >= ColW'(k_eff - 3'd1));
         acc_ff   <= '0;
         q_ff     <= '0;
      end
      if (cmd.acc_step) begin
         acc_ff <= acc_ff + col_sum;
         q_ff   <= q_ff + WinW'(1);
      end
      if (cmd.mul) begin
         if (acc_ff > 0 && valid_ff)
            prod_ff <= ProdW'(acc_ff[SumW-2:0]) * ProdW'(recip(k_eff));
         else
            prod_ff <= '0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= (quo > 255) ? 8'd255 : quo[7:0];
         rsp_user_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign sts.col_last = (q_ff == WinW'(MaxKernel - 1));
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser    = rsp_user_ff;

`ifndef ASSERT_OFF
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0) else $error("response without window");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> {1'b0, c_ff} < w_eff || $past(csr_we)) else $error("column out of row");
   a_mul_after_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> $past(cmd.acc_step) && $past(sts.col_last)) else $error("early scaling");
`endif

endmodule
